>>> rtl/core/rdc_pkg.sv
// Shared types and codes for the range distinct-count block.
`default_nettype none

package rdc_pkg;

	// Field widths fixed by the item formats
	localparam int unsigned POS_W    = 10;
	localparam int unsigned COLOUR_W = 10;
	localparam int unsigned HIST_W   = 11;
	localparam int unsigned COUNT_W  = 11;

	// Item actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Window moves commanded by the controller
	localparam logic [2:0] WIN_NONE = 3'd0;
	localparam logic [2:0] WIN_SEED = 3'd1;
	localparam logic [2:0] WIN_GL   = 3'd2;  // grow left
	localparam logic [2:0] WIN_GR   = 3'd3;  // grow right
	localparam logic [2:0] WIN_SL   = 3'd4;  // shrink left
	localparam logic [2:0] WIN_SR   = 3'd5;  // shrink right

	typedef struct packed {
		logic                action;
		logic [POS_W-1:0]    position;
		logic [POS_W-1:0]    right_bound;
		logic [COLOUR_W-1:0] new_value;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] distinct_count;
		logic               range_error;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic       latch;      // capture input beat
		logic       clear;      // clearing pass step
		logic [2:0] win_op;
		logic       elem_rd;
		logic       elem_wr;
		logic       hist_rd;
		logic       hist_sel_new; // histogram colour from new_value, not element
		logic       hist_wr;
		logic       hist_dec;
		logic       emit_ok;
		logic       emit_err;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_done;
		logic is_query;
		logic wr_bad;
		logic wr_in_win;
		logic q_bad;
		logic empty;
		logic grow_l;
		logic grow_r;
		logic shrink_l;
		logic shrink_r;
	} dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/rdc_ctrl.sv
// Controller state machine sequencing clears, writes and window slides.
`default_nettype none

module rdc_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire rdc_pkg::dp_status_t status,
	output rdc_pkg::ctl_cmd_t     cmd
);

	localparam logic [3:0] S_CLEAR      = 4'd0;
	localparam logic [3:0] S_IDLE       = 4'd1;
	localparam logic [3:0] S_DECODE     = 4'd2;
	localparam logic [3:0] S_STEP       = 4'd3;
	localparam logic [3:0] S_ERD        = 4'd4;
	localparam logic [3:0] S_HRD        = 4'd5;
	localparam logic [3:0] S_HWR        = 4'd6;
	localparam logic [3:0] S_W_ERD      = 4'd7;
	localparam logic [3:0] S_W_HRD_OLD  = 4'd8;
	localparam logic [3:0] S_W_HWR_OLD  = 4'd9;
	localparam logic [3:0] S_W_HRD_NEW  = 4'd10;
	localparam logic [3:0] S_W_HWR_NEW  = 4'd11;
	localparam logic [3:0] S_W_EWR      = 4'd12;

	logic [3:0] state_q, state_d;
	logic       dec_q, dec_d;

	assign busy = (state_q != S_IDLE);

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		dec_d   = dec_q;
		cmd     = '0;
		cmd.win_op = rdc_pkg::WIN_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!status.is_query) begin
					if (status.wr_bad) begin
						state_d = S_IDLE;
					end else if (status.wr_in_win) begin
						state_d = S_W_ERD;
					end else begin
						cmd.elem_wr = 1'b1;
						state_d     = S_IDLE;
					end
				end else if (status.q_bad) begin
					cmd.emit_err = 1'b1;
					state_d      = S_IDLE;
				end else if (status.empty) begin
					cmd.win_op = rdc_pkg::WIN_SEED;
					dec_d      = 1'b0;
					state_d    = S_ERD;
				end else begin
					state_d = S_STEP;
				end
			end
			// Grow before shrinking so the window never empties
			S_STEP: begin
				if (status.grow_l) begin
					cmd.win_op = rdc_pkg::WIN_GL;
					dec_d      = 1'b0;
					state_d    = S_ERD;
				end else if (status.grow_r) begin
					cmd.win_op = rdc_pkg::WIN_GR;
					dec_d      = 1'b0;
					state_d    = S_ERD;
				end else if (status.shrink_l) begin
					cmd.win_op = rdc_pkg::WIN_SL;
					dec_d      = 1'b1;
					state_d    = S_ERD;
				end else if (status.shrink_r) begin
					cmd.win_op = rdc_pkg::WIN_SR;
					dec_d      = 1'b1;
					state_d    = S_ERD;
				end else begin
					cmd.emit_ok = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_ERD: begin
				cmd.elem_rd = 1'b1;
				state_d     = S_HRD;
			end
			S_HRD: begin
				cmd.hist_rd = 1'b1;
				state_d     = S_HWR;
			end
			S_HWR: begin
				cmd.hist_wr  = 1'b1;
				cmd.hist_dec = dec_q;
				state_d      = S_STEP;
			end
			// In-window write: drop old colour, add new, then store element
			S_W_ERD: begin
				cmd.elem_rd = 1'b1;
				state_d     = S_W_HRD_OLD;
			end
			S_W_HRD_OLD: begin
				cmd.hist_rd = 1'b1;
				state_d     = S_W_HWR_OLD;
			end
			S_W_HWR_OLD: begin
				cmd.hist_wr  = 1'b1;
				cmd.hist_dec = 1'b1;
				state_d      = S_W_HRD_NEW;
			end
			S_W_HRD_NEW: begin
				cmd.hist_rd      = 1'b1;
				cmd.hist_sel_new = 1'b1;
				state_d          = S_W_HWR_NEW;
			end
			S_W_HWR_NEW: begin
				cmd.hist_wr = 1'b1;
				state_d     = S_W_EWR;
			end
			S_W_EWR: begin
				cmd.elem_wr = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			dec_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			dec_q   <= dec_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rdc_datapath.sv
// Datapath: element and histogram memories, window registers, distinct count.
`default_nettype none

module rdc_datapath #(
	parameter int unsigned ARRAY_DEPTH  = 1024,
	parameter int unsigned COLOUR_COUNT = 1024
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire rdc_pkg::in_item_t item,
	input  wire rdc_pkg::ctl_cmd_t cmd,
	output rdc_pkg::dp_status_t   status,
	output rdc_pkg::out_item_t    result,
	output logic                  done
);

	localparam int unsigned AW   = $clog2(ARRAY_DEPTH);
	localparam int unsigned CAW  = $clog2(COLOUR_COUNT);
	localparam int unsigned MAXD = (ARRAY_DEPTH > COLOUR_COUNT) ? ARRAY_DEPTH : COLOUR_COUNT;
	localparam int unsigned CW   = $clog2(MAXD);

	localparam int unsigned PW = rdc_pkg::POS_W;
	localparam int unsigned VW = rdc_pkg::COLOUR_W;
	localparam int unsigned HW = rdc_pkg::HIST_W;
	localparam int unsigned NW = rdc_pkg::COUNT_W;

	logic [VW-1:0] elem_mem [ARRAY_DEPTH];
	logic [HW-1:0] hist_mem [COLOUR_COUNT];

	rdc_pkg::in_item_t item_q;
	logic [PW-1:0]     left_q, right_q, idx_q;
	logic              empty_q;
	logic [NW-1:0]     total_q;
	logic [VW-1:0]     colour_q;
	logic [CW-1:0]     clr_cnt_q;
	logic [VW-1:0]     elem_rdata_q;
	logic [HW-1:0]     hist_rdata_q;
	rdc_pkg::out_item_t result_q;
	logic              done_q;

	logic [31:0]   idx_ext, col_ext;
	logic [VW-1:0] colour_mux, hist_col;
	logic [AW-1:0] elem_addr;
	logic [CAW-1:0] hist_addr;
	logic          elem_we, hist_we;
	logic [VW-1:0] elem_wdata;
	logic [HW-1:0] hist_wdata, hist_upd;
	logic          clr_elem, clr_hist;

	// Status decode from the latched beat and window
	always_comb begin
		status.clr_done  = (clr_cnt_q == CW'(MAXD - 1));
		status.is_query  = (item_q.action == rdc_pkg::ACT_QUERY);
		status.wr_bad    = (32'(item_q.position) >= 32'(ARRAY_DEPTH)) ||
		                   (32'(item_q.new_value) >= 32'(COLOUR_COUNT));
		status.wr_in_win = !empty_q && (item_q.position >= left_q) &&
		                   (item_q.position <= right_q);
		status.q_bad     = (item_q.position > item_q.right_bound) ||
		                   (32'(item_q.right_bound) >= 32'(ARRAY_DEPTH));
		status.empty     = empty_q;
		status.grow_l    = (left_q > item_q.position);
		status.grow_r    = (right_q < item_q.right_bound);
		status.shrink_l  = (left_q < item_q.position);
		status.shrink_r  = (right_q > item_q.right_bound);
	end

	// Memory address and write-data selection
	always_comb begin
		colour_mux = cmd.hist_sel_new ? item_q.new_value : elem_rdata_q;
		hist_col   = cmd.hist_wr ? colour_q : colour_mux;
		idx_ext    = 32'(idx_q);
		col_ext    = 32'(hist_col);
		clr_elem   = cmd.clear && (32'(clr_cnt_q) < 32'(ARRAY_DEPTH));
		clr_hist   = cmd.clear && (32'(clr_cnt_q) < 32'(COLOUR_COUNT));

		elem_addr  = cmd.clear ? clr_cnt_q[AW-1:0] : idx_ext[AW-1:0];
		elem_we    = clr_elem || cmd.elem_wr;
		elem_wdata = cmd.clear ? '0 : item_q.new_value;

		// Increment, or decrement where the count is not already zero
		if (cmd.hist_dec)
			hist_upd = (hist_rdata_q != '0) ? hist_rdata_q - HW'(1) : hist_rdata_q;
		else
			hist_upd = hist_rdata_q + HW'(1);

		hist_addr  = cmd.clear ? clr_cnt_q[CAW-1:0] : col_ext[CAW-1:0];
		hist_we    = clr_hist || cmd.hist_wr;
		hist_wdata = cmd.clear ? '0 : hist_upd;
	end

	// Element memory
	always_ff @(posedge clk) begin
		if (elem_we) elem_mem[elem_addr] <= elem_wdata;
		if (cmd.elem_rd) elem_rdata_q <= elem_mem[elem_addr];
	end

	// Histogram memory
	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_addr] <= hist_wdata;
		if (cmd.hist_rd) hist_rdata_q <= hist_mem[hist_addr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) item_q <= item;
		if (cmd.hist_rd) colour_q <= colour_mux;
		if (cmd.emit_ok) begin
			result_q.distinct_count <= total_q;
			result_q.range_error    <= 1'b0;
		end else if (cmd.emit_err) begin
			result_q.distinct_count <= '0;
			result_q.range_error    <= 1'b1;
		end
	end

	// Window, index, distinct count and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			right_q   <= '0;
			idx_q     <= '0;
			empty_q   <= 1'b1;
			total_q   <= '0;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.emit_ok || cmd.emit_err;
			if (cmd.clear && !status.clr_done) clr_cnt_q <= clr_cnt_q + CW'(1);
			if (cmd.latch) idx_q <= item.position;

			case (cmd.win_op)
				rdc_pkg::WIN_SEED: begin
					left_q  <= item_q.position;
					right_q <= item_q.position;
					idx_q   <= item_q.position;
					empty_q <= 1'b0;
				end
				rdc_pkg::WIN_GL: begin
					left_q <= left_q - PW'(1);
					idx_q  <= left_q - PW'(1);
				end
				rdc_pkg::WIN_GR: begin
					right_q <= right_q + PW'(1);
					idx_q   <= right_q + PW'(1);
				end
				rdc_pkg::WIN_SL: begin
					idx_q  <= left_q;
					left_q <= left_q + PW'(1);
				end
				rdc_pkg::WIN_SR: begin
					idx_q   <= right_q;
					right_q <= right_q - PW'(1);
				end
				default: begin
				end
			endcase

			// Distinct count follows histogram transitions to and from zero
			if (cmd.hist_wr) begin
				if (!cmd.hist_dec && hist_rdata_q == '0)
					total_q <= total_q + NW'(1);
				else if (cmd.hist_dec && hist_rdata_q == HW'(1) && total_q != '0)
					total_q <= total_q - NW'(1);
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

`default_nettype wire

>>> rtl/core/range_distinct_count_with_updates_top.sv
// Top level: distinct colour count over a sliding window with element updates.
`default_nettype none

// Takes one beat when start is high and busy is low. After reset the block
// runs a clearing pass over both memories with busy high. A write in range
// outside the window stores the element; a write inside it also updates the
// histogram (old colour removed, new colour added). A query moves the window
// one step at a time (a step decision, one element read, one histogram read
// and one histogram write, through the single port of each memory), the step
// count being the distance moved by both bounds; the first query after reset
// first seeds the window, and a query with bad bounds gives an error result.
// Each query gives one result beat on done, in the cycle after its last busy
// cycle, for exactly one cycle, which the receiver must take then; it cannot
// stall the block. Writes give no beat.
module range_distinct_count_with_updates_top #(
	parameter int unsigned ARRAY_DEPTH  = 1024,
	parameter int unsigned COLOUR_COUNT = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire rdc_pkg::in_item_t item,
	output rdc_pkg::out_item_t  result,
	output logic                done
);

	rdc_pkg::ctl_cmd_t   cmd;
	rdc_pkg::dp_status_t status;

	rdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	rdc_datapath #(
		.ARRAY_DEPTH  (ARRAY_DEPTH),
		.COLOUR_COUNT (COLOUR_COUNT)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result),
		.done   (done)
	);

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the range distinct-count block with element updates.
`timescale 1ns / 1ps

module tb_top;

	localparam int LAST_POS     = 1023;
	localparam int RANDOM_BEATS = 1147;
	localparam int PBITS        = rdc_pkg::POS_W;
	localparam int CBITS        = rdc_pkg::COLOUR_W;

	// Tracks the window and histogram, queues the expected count for each query beat
	class distinct_scoreboard;
		bit [rdc_pkg::COLOUR_W-1:0] colour_of [1024];
		bit [rdc_pkg::HIST_W-1:0]   colour_tally [1024];
		bit [rdc_pkg::POS_W-1:0]    win_lo;
		bit [rdc_pkg::POS_W-1:0]    win_hi;
		bit                         win_held;
		bit [rdc_pkg::COUNT_W-1:0]  distinct_now;
		rdc_pkg::out_item_t         count_due_q [$];
		int                         mismatches;
		int                         checked;
		int                         writes;
		int                         inwin_writes;
		int                         queries;
		int                         bad_queries;
		int                         peak_count;
		int                         widest;

		function void tally_up(bit [rdc_pkg::COLOUR_W-1:0] c);
			colour_tally[c]++;
			if (colour_tally[c] == 1)
				distinct_now++;
		endfunction

		function void tally_down(bit [rdc_pkg::COLOUR_W-1:0] c);
			if (colour_tally[c] == 0)
				return;
			colour_tally[c]--;
			if (colour_tally[c] == 0 && distinct_now != 0)
				distinct_now--;
		endfunction

		function int pending();
			return count_due_q.size();
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH @%0t: %s", $realtime, what);
			mismatches++;
		endtask

		// Accepted input beat: update the model, queue a result for queries
		function void note_beat(rdc_pkg::in_item_t b);
			rdc_pkg::out_item_t want;
			want = '0;
			if (b.action == rdc_pkg::ACT_WRITE) begin
				writes++;
				if (win_held && b.position >= win_lo && b.position <= win_hi) begin
					inwin_writes++;
					tally_down(colour_of[b.position]);
					tally_up(b.new_value);
				end
				colour_of[b.position] = b.new_value;
				return;
			end
			queries++;
			if (b.position > b.right_bound) begin
				bad_queries++;
				want.range_error = 1'b1;
			end else begin
				// first query seeds the window at its left bound
				if (!win_held) begin
					win_lo = b.position;
					win_hi = b.position;
					tally_up(colour_of[b.position]);
					win_held = 1'b1;
				end
				// grow both ends before shrinking, as the block does
				while (win_lo > b.position) begin
					win_lo--;
					tally_up(colour_of[win_lo]);
				end
				while (win_hi < b.right_bound) begin
					win_hi++;
					tally_up(colour_of[win_hi]);
				end
				while (win_lo < b.position) begin
					tally_down(colour_of[win_lo]);
					win_lo++;
				end
				while (win_hi > b.right_bound) begin
					tally_down(colour_of[win_hi]);
					win_hi--;
				end
				want.distinct_count = distinct_now;
				if (int'(distinct_now) > peak_count)
					peak_count = int'(distinct_now);
				if (int'(win_hi) - int'(win_lo) + 1 > widest)
					widest = int'(win_hi) - int'(win_lo) + 1;
			end
			count_due_q.push_back(want);
		endfunction

		// Result beat: compare against the oldest outstanding query
		task check_beat(rdc_pkg::out_item_t got);
			rdc_pkg::out_item_t want;
			if (count_due_q.size() == 0) begin
				report_mismatch($sformatf("result beat with no query outstanding (count %0d)",
					got.distinct_count));
				return;
			end
			want = count_due_q.pop_front();
			checked++;
			if (got.distinct_count !== want.distinct_count)
				report_mismatch($sformatf("query %0d: distinct_count %0d, expected %0d",
					checked, got.distinct_count, want.distinct_count));
			if (got.range_error !== want.range_error)
				report_mismatch($sformatf("query %0d: range_error %b, expected %b",
					checked, got.range_error, want.range_error));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	rdc_pkg::in_item_t  item;
	rdc_pkg::out_item_t result;
	logic               done;
	bit                 calm;

	distinct_scoreboard sb;

	range_distinct_count_with_updates_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.result (result),
		.done   (done)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result monitor: the block cannot be stalled, so every strobe is checked
	always @(posedge clk) begin
		if (done === 1'b1)
			sb.check_beat(result);
	end

	function automatic int clip(int v);
		if (v < 0)
			return 0;
		if (v > LAST_POS)
			return LAST_POS;
		return v;
	endfunction

	// Present one beat, hold it until taken, then maybe idle a while
	task send_beat(rdc_pkg::in_item_t b);
		item  <= b;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_beat(b);
		if (!calm && $urandom_range(0, 99) < 38) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task send_query(int l, int r);
		rdc_pkg::in_item_t b;
		b.action      = rdc_pkg::ACT_QUERY;
		b.position    = PBITS'(l);
		b.right_bound = PBITS'(r);
		b.new_value   = CBITS'($urandom_range(0, LAST_POS));
		send_beat(b);
	endtask

	task send_write(int p, int c);
		rdc_pkg::in_item_t b;
		b.action      = rdc_pkg::ACT_WRITE;
		b.position    = PBITS'(p);
		b.right_bound = PBITS'($urandom_range(0, LAST_POS));
		b.new_value   = CBITS'(c);
		send_beat(b);
	endtask

	// Hold off the sender until every query has answered
	task drain_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin : stimulus
		int lo;
		int hi;
		int l;
		int r;
		int p;
		int c;
		int roll;
		int kind;

		sb     = new;
		calm   = 1'b0;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: writes before any window, bad bounds, seeding, extremes
		send_write(0, 5);
		send_write(LAST_POS, LAST_POS);
		send_write(2, 5);
		send_query(7, 6);
		send_query(1, 2);
		send_write(2, 9);
		send_write(1, 9);
		send_query(1, 2);
		send_write(5, 7);
		send_query(0, 5);
		drain_results();
		send_query(0, LAST_POS);
		send_write(512, 0);
		send_write(LAST_POS, 0);
		send_query(LAST_POS, LAST_POS);
		send_query(0, 0);
		send_query(LAST_POS, 0);
		send_query(0, 0);
		send_write(0, LAST_POS);
		send_query(0, 0);
		send_query(3, 3);
		send_write(3, int'(sb.colour_of[3]));
		send_query(2, 4);
		send_query(0, LAST_POS);

		// Random: mostly local window moves and writes near the window
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			calm = (i >= 500 && i < 700);
			if (i == 400)
				drain_results();
			lo   = int'(sb.win_lo);
			hi   = int'(sb.win_hi);
			roll = $urandom_range(0, 99);
			kind = $urandom_range(0, 99);
			if (roll < 45) begin
				if (kind < 4) begin
					l = $urandom_range(1, LAST_POS);
					r = $urandom_range(0, l - 1);
				end else if (kind < 6) begin
					l = $urandom_range(0, 3);
					r = $urandom_range(LAST_POS - 3, LAST_POS);
				end else if (kind < 13) begin
					l = $urandom_range(0, LAST_POS);
					r = clip(l + int'($urandom_range(0, 48)));
				end else begin
					l = clip(lo + int'($urandom_range(0, 12)) - 6);
					r = clip(hi + int'($urandom_range(0, 12)) - 6);
					if (l > r) begin
						p = l;
						l = r;
						r = p;
					end
				end
				send_query(l, r);
			end else begin
				if (kind < 65 && sb.win_held)
					p = $urandom_range(lo, hi);
				else if (kind < 82)
					p = clip(lo - 8 + int'($urandom_range(0, hi - lo + 16)));
				else
					p = $urandom_range(0, LAST_POS);
				roll = $urandom_range(0, 99);
				if (roll < 45)
					c = $urandom_range(0, 7);
				else if (roll < 55)
					c = $urandom_range(LAST_POS - 7, LAST_POS);
				else
					c = $urandom_range(0, LAST_POS);
				send_write(p, c);
			end
		end

		// Wind down: all answers in, then a quiet tail for stray strobes
		drain_results();
		repeat (64) @(posedge clk);

		$display("Covered %0d writes (%0d inside the window) and %0d queries (%0d bad bounds).",
			sb.writes, sb.inwin_writes, sb.queries, sb.bad_queries);
		$display("Results checked: %0d; peak distinct count %0d; widest window %0d.",
			sb.checked, sb.peak_count, sb.widest);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#100_000_000;
		$display("Timed out with %0d results outstanding.", sb.pending());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/rdc_pkg.sv
rtl/core/rdc_ctrl.sv
rtl/core/rdc_datapath.sv
rtl/core/range_distinct_count_with_updates_top.sv
sim/tb_top.sv
